// ----- sv/ddik_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ddik_pkg;

    // Field and register widths
    localparam int SPD_W      = 16;
    localparam int CFG_W      = 15;
    localparam int SPACING_W  = 13;
    localparam int WHEEL_W    = SPD_W + 1;
    localparam int MAG_W      = SPD_W;
    localparam int QUO_W      = CFG_W;
    localparam int NUM_W      = MAG_W + CFG_W;
    localparam int HALF_SHIFT = 13;

    // Register map
    localparam int INDEX_W = 3;
    typedef enum logic [INDEX_W-1:0] {
        REG_MIN_LINEAR    = 3'd0,
        REG_MAX_LINEAR    = 3'd1,
        REG_MIN_ANGULAR   = 3'd2,
        REG_MAX_ANGULAR   = 3'd3,
        REG_WHEEL_SPACING = 3'd4
    } reg_index_t;

    // Register reset values
    localparam logic [CFG_W-1:0]     RST_MIN_LINEAR    = 15'd41;
    localparam logic [CFG_W-1:0]     RST_MAX_LINEAR    = 15'd2048;
    localparam logic [CFG_W-1:0]     RST_MIN_ANGULAR   = 15'd41;
    localparam logic [CFG_W-1:0]     RST_MAX_ANGULAR   = 15'd8192;
    localparam logic [SPACING_W-1:0] RST_WHEEL_SPACING = 13'd1229;

    localparam int DEFAULT_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [SPD_W-1:0] linear_v;
        logic signed [SPD_W-1:0] angular_w;
    } in_word_t;

    typedef struct packed {
        logic signed [SPD_W-1:0] left_speed;
        logic signed [SPD_W-1:0] right_speed;
        logic                    was_scaled;
    } out_word_t;

    typedef struct packed {
        logic [CFG_W-1:0]     min_linear;
        logic [CFG_W-1:0]     max_linear;
        logic [CFG_W-1:0]     min_angular;
        logic [CFG_W-1:0]     max_angular;
        logic [SPACING_W-1:0] wheel_spacing;
    } cfg_t;

    // Unscaled wheel speeds passed from front to back
    typedef struct packed {
        logic signed [WHEEL_W-1:0] left;
        logic signed [WHEEL_W-1:0] right;
    } wheel_pair_t;

endpackage

`default_nettype wire

// ----- sv/diff_drive_inverse_kinematics.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Differential-drive inverse kinematics. Each input word carries a linear
// speed and a yaw rate (1/4096 m/s and 1/4096 rad/s); each result word gives
// the left and right wheel speeds in 1/4096 m/s and a flag that is set when
// both wheels were scaled down, the faster to max_linear. Commands inside
// their deadband become zero, larger ones are clamped to their limit. The
// block takes one word per clock while in_stall is low. A word passes the
// three front stages (shaping, spacing multiply, wheel sums), the queue,
// then the magnitude stage, the limit multiply, a 15-stage quotient pipeline
// (one quotient bit per stage) and the output register. Configuration
// registers are written through wr_en / wr_index / wr_data and must only
// change while no word is in flight.
module diff_drive_inverse_kinematics
    import ddik_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_word_t           in_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_word_t               out_word,
    input  wire logic               wr_en,
    input  wire logic [INDEX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]   wr_data
);

    cfg_t        cfg_reg;
    logic        push;
    wheel_pair_t push_data;
    logic        full;
    logic        pop;
    wheel_pair_t pop_data;
    logic        empty;

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_linear    <= RST_MIN_LINEAR;
            cfg_reg.max_linear    <= RST_MAX_LINEAR;
            cfg_reg.min_angular   <= RST_MIN_ANGULAR;
            cfg_reg.max_angular   <= RST_MAX_ANGULAR;
            cfg_reg.wheel_spacing <= RST_WHEEL_SPACING;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_MIN_LINEAR:    cfg_reg.min_linear    <= wr_data;
                REG_MAX_LINEAR:    cfg_reg.max_linear    <= wr_data;
                REG_MIN_ANGULAR:   cfg_reg.min_angular   <= wr_data;
                REG_MAX_ANGULAR:   cfg_reg.max_angular   <= wr_data;
                REG_WHEEL_SPACING: cfg_reg.wheel_spacing <= wr_data[SPACING_W-1:0];
                default:           ;
            endcase
        end
    end

    ddik_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    ddik_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ddik_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .pop_data  (pop_data),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ----- sv/ddik_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ddik_front
    import ddik_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_word_t    in_word,
    input  wire cfg_t        cfg,
    output logic             push,
    output wheel_pair_t      push_data,
    input  wire logic        full
);

    localparam int PROD_W = SPD_W + SPACING_W + 1;
    localparam logic signed [PROD_W-1:0] ROUND_ADJ = PROD_W'((1 << HALF_SHIFT) - 1);

    // Deadband first, then clamp with sign kept
    function automatic logic signed [SPD_W-1:0] shape_cmd(
        input logic signed [SPD_W-1:0] x,
        input logic [CFG_W-1:0]        lo,
        input logic [CFG_W-1:0]        hi
    );
        logic [SPD_W:0]          a;
        logic signed [SPD_W-1:0] r;
        a = x[SPD_W-1] ? ((SPD_W+1)'(0) - {x[SPD_W-1], x}) : {1'b0, x};
        if (a < {2'b00, lo})
            r = '0;
        else if (a > {2'b00, hi})
            r = x[SPD_W-1] ? (SPD_W'(0) - {1'b0, hi}) : {1'b0, hi};
        else
            r = x;
        return r;
    endfunction

    logic                      a_valid_reg;
    logic signed [SPD_W-1:0]   a_v_reg;
    logic signed [SPD_W-1:0]   a_w_reg;
    logic                      b_valid_reg;
    logic signed [SPD_W-1:0]   b_v_reg;
    logic signed [PROD_W-1:0]  b_prod_reg;
    logic                      c_valid_reg;
    wheel_pair_t               c_pair_reg;

    logic                      advance;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_adj;
    logic signed [WHEEL_W-1:0] half_term;
    logic signed [WHEEL_W-1:0] v_ext;
    wheel_pair_t               c_pair_next;

    // Move the whole front on when the last stage can drain
    assign advance   = !c_valid_reg || !full;
    assign in_stall  = !advance;
    assign push      = c_valid_reg && !full;
    assign push_data = c_pair_reg;

    // Multiply yaw rate by wheel spacing
    assign prod_next = $signed({{(PROD_W-SPD_W){a_w_reg[SPD_W-1]}}, a_w_reg})
                     * $signed({{(PROD_W-SPACING_W){1'b0}}, cfg.wheel_spacing});

    // Halve spacing with truncation toward zero, then form both wheels
    always_comb
    begin
        prod_adj          = b_prod_reg[PROD_W-1] ? (b_prod_reg + ROUND_ADJ) : b_prod_reg;
        half_term         = WHEEL_W'(prod_adj >>> HALF_SHIFT);
        v_ext             = {b_v_reg[SPD_W-1], b_v_reg};
        c_pair_next.left  = v_ext - half_term;
        c_pair_next.right = v_ext + half_term;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_v_reg    <= shape_cmd(in_word.linear_v, cfg.min_linear, cfg.max_linear);
            a_w_reg    <= shape_cmd(in_word.angular_w, cfg.min_angular, cfg.max_angular);
            b_v_reg    <= a_v_reg;
            b_prod_reg <= prod_next;
            c_pair_reg <= c_pair_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ddik_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ddik_queue
    import ddik_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire wheel_pair_t push_data,
    output logic             full,
    input  wire logic        pop,
    output wheel_pair_t      pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    wheel_pair_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Track pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store word
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ----- sv/ddik_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ddik_back
    import ddik_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    output logic             pop,
    input  wire wheel_pair_t pop_data,
    input  wire cfg_t        cfg,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_word_t        out_word
);

    localparam int STAGES = QUO_W;

    typedef struct packed {
        logic [NUM_W-1:0]        rem_l;
        logic [NUM_W-1:0]        rem_r;
        logic [QUO_W-1:0]        quo_l;
        logic [QUO_W-1:0]        quo_r;
        logic [MAG_W-1:0]        den;
        logic                    neg_l;
        logic                    neg_r;
        logic                    scaled;
        logic signed [SPD_W-1:0] left;
        logic signed [SPD_W-1:0] right;
    } div_stage_t;

    logic                    advance;

    logic                    s0_valid_reg;
    logic [MAG_W-1:0]        s0_abs_l_reg;
    logic [MAG_W-1:0]        s0_abs_r_reg;
    logic                    s0_neg_l_reg;
    logic                    s0_neg_r_reg;
    logic signed [SPD_W-1:0] s0_left_reg;
    logic signed [SPD_W-1:0] s0_right_reg;

    logic [STAGES:0]         div_valid_reg;
    div_stage_t              div_reg  [STAGES+1];
    div_stage_t              div_next [STAGES+1];

    logic                    out_valid_reg;
    out_word_t               out_word_reg;
    out_word_t               out_word_next;

    // Drain the whole back end when the output register frees up
    assign advance   = !out_valid_reg || !out_stall;
    assign pop       = advance && !empty;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Load the quotient pipe: scale numerators and pick the larger magnitude,
    // then resolve one quotient bit per stage, most significant first
    always_comb
    begin
        div_next[0].rem_l  = NUM_W'(s0_abs_l_reg)
                           * {{(NUM_W-CFG_W){1'b0}}, cfg.max_linear};
        div_next[0].rem_r  = NUM_W'(s0_abs_r_reg)
                           * {{(NUM_W-CFG_W){1'b0}}, cfg.max_linear};
        div_next[0].quo_l  = '0;
        div_next[0].quo_r  = '0;
        div_next[0].den    = (s0_abs_l_reg > s0_abs_r_reg) ? s0_abs_l_reg : s0_abs_r_reg;
        div_next[0].scaled = (div_next[0].den > {1'b0, cfg.max_linear});
        div_next[0].neg_l  = s0_neg_l_reg;
        div_next[0].neg_r  = s0_neg_r_reg;
        div_next[0].left   = s0_left_reg;
        div_next[0].right  = s0_right_reg;
        for (int k = 0; k < STAGES; k++)
        begin
            div_next[k+1] = div_reg[k];
            if (div_reg[k].rem_l >= (NUM_W'(div_reg[k].den) << (STAGES - 1 - k)))
            begin
                div_next[k+1].rem_l = div_reg[k].rem_l
                                    - (NUM_W'(div_reg[k].den) << (STAGES - 1 - k));
                div_next[k+1].quo_l[STAGES-1-k] = 1'b1;
            end
            if (div_reg[k].rem_r >= (NUM_W'(div_reg[k].den) << (STAGES - 1 - k)))
            begin
                div_next[k+1].rem_r = div_reg[k].rem_r
                                    - (NUM_W'(div_reg[k].den) << (STAGES - 1 - k));
                div_next[k+1].quo_r[STAGES-1-k] = 1'b1;
            end
        end
    end

    // Restore signs, or pass the unscaled wheels
    always_comb
    begin
        out_word_next.was_scaled = div_reg[STAGES].scaled;
        if (div_reg[STAGES].scaled)
        begin
            out_word_next.left_speed  = div_reg[STAGES].neg_l
                ? (SPD_W'(0) - {1'b0, div_reg[STAGES].quo_l})
                : {1'b0, div_reg[STAGES].quo_l};
            out_word_next.right_speed = div_reg[STAGES].neg_r
                ? (SPD_W'(0) - {1'b0, div_reg[STAGES].quo_r})
                : {1'b0, div_reg[STAGES].quo_r};
        end
        else
        begin
            out_word_next.left_speed  = div_reg[STAGES].left;
            out_word_next.right_speed = div_reg[STAGES].right;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            div_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg  <= pop;
            div_valid_reg <= {div_valid_reg[STAGES-1:0], s0_valid_reg};
            out_valid_reg <= div_valid_reg[STAGES];
        end
    end

    // Advance payload; take magnitudes as the word leaves the queue
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_neg_l_reg <= pop_data.left[WHEEL_W-1];
            s0_neg_r_reg <= pop_data.right[WHEEL_W-1];
            s0_abs_l_reg <= pop_data.left[WHEEL_W-1]
                ? MAG_W'(WHEEL_W'(0) - pop_data.left) : pop_data.left[MAG_W-1:0];
            s0_abs_r_reg <= pop_data.right[WHEEL_W-1]
                ? MAG_W'(WHEEL_W'(0) - pop_data.right) : pop_data.right[MAG_W-1:0];
            s0_left_reg  <= pop_data.left[SPD_W-1:0];
            s0_right_reg <= pop_data.right[SPD_W-1:0];
            for (int k = 0; k <= STAGES; k++)
                div_reg[k] <= div_next[k];
            out_word_reg <= out_word_next;
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_word_reg)))
        else $error("result word changed while stalled");

    a_scaled_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid_reg[STAGES] && div_reg[STAGES].scaled)
            |-> (div_reg[STAGES].quo_l <= cfg.max_linear
                 && div_reg[STAGES].quo_r <= cfg.max_linear))
        else $error("scaled wheel speed above limit");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !(out_valid_reg && out_stall))
        else $error("queue read while back end stalled");

endmodule

`default_nettype wire
